// File: sv/pabd_pkg.sv
// shared types, constants and byte helpers for the pnm decoder
`default_nettype none

package pabd_pkg;

    // file characters
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_4    = 8'h34;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_SP   = 8'h20;

    // result status codes
    localparam logic [2:0] STS_SAMPLE    = 3'd0;
    localparam logic [2:0] STS_DONE      = 3'd1;
    localparam logic [2:0] STS_BAD_NUM   = 3'd2;
    localparam logic [2:0] STS_BAD_DIM   = 3'd3;
    localparam logic [2:0] STS_BAD_MAXV  = 3'd4;
    localparam logic [2:0] STS_TRUNC     = 3'd5;
    localparam logic [2:0] STS_BAD_MAGIC = 3'd6;

    // format kinds
    localparam logic [1:0] KIND_P1 = 2'd0;
    localparam logic [1:0] KIND_P3 = 2'd2;
    localparam logic [1:0] KIND_P4 = 2'd3;

    localparam int          ACC_W   = 17;
    localparam logic [16:0] ACC_MAX = 17'h1ffff;
    localparam int          NUM_W   = 25;
    localparam int          DEN_W   = 16;
    localparam int          TDATA_W = 40;
    localparam int          TUSER_W = 4;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_DIGIT,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_SAMPLES,
        PH_RASTER,
        PH_IDLE
    } phase_t;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_FRONT,
        OP_FINISH,
        OP_WAITDIV,
        OP_SDIV,
        OP_CHK,
        OP_POST,
        OP_RAST,
        OP_RDONE,
        OP_FLUSH
    } op_t;

    typedef enum logic [3:0] {
        CS_WAIT,
        CS_FRONT,
        CS_FINISH,
        CS_DIV,
        CS_SDIV,
        CS_CHK,
        CS_POST,
        CS_RAST,
        CS_RDONE,
        CS_FLUSH
    } ctl_state_t;

    typedef enum logic [1:0] {
        FR_DONE,
        FR_FINISH,
        FR_EOF,
        FR_RASTER
    } front_t;

    typedef enum logic [1:0] {
        FIN_POST,
        FIN_DIV,
        FIN_SAMPLE
    } fin_t;

    typedef struct packed {
        op_t  op;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic   stall;
        front_t front;
        fin_t   fin;
        logic   div_done;
        logic   rast_end;
    } stat_t;

    typedef struct packed {
        logic        color;
        logic [12:0] height;
        logic [12:0] width;
        logic [2:0]  status;
        logic [7:0]  sample;
    } res_t;

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

`default_nettype wire

// File: sv/pabd_div.sv
// restoring divider, one quotient bit per cycle, for maxval scaling
`default_nettype none

module pabd_div
    import pabd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [7:0]            quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] sh_reg, sh_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, sh_reg[NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        diff      = trial - {1'b0, den_reg};
        run_next  = run_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next  = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNT_W'(NUM_W - 1);
            rem_next  = '0;
            sh_next   = num;
            den_next  = den;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            sh_next  = {sh_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = sh_reg[7:0];

endmodule

`default_nettype wire

// File: sv/pabd_dp.sv
// datapath: header parser registers, sample conversion, result staging
`default_nettype none

module pabd_dp
    import pabd_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       cmd,
    output stat_t           stat,
    input  wire logic [7:0] data_in,
    input  wire logic       eof_in,
    input  wire logic       out_ready,
    output res_t            out_res,
    output logic            out_last,
    output logic            out_valid
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam longint unsigned MAX_SAMPLES = 3 * longint'(MAX_DIM) * longint'(MAX_DIM);
    localparam int SL_W = $clog2(MAX_SAMPLES + 1);

    phase_t           ph_reg, ph_next;
    logic [1:0]       kind_reg, kind_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             seen_reg, seen_next;
    logic             cmt_reg, cmt_next;
    logic [DIM_W-1:0] wid_reg, wid_next;
    logic [DIM_W-1:0] hgt_reg, hgt_next;
    logic [15:0]      maxv_reg, maxv_next;
    logic [SL_W-1:0]  left_reg, left_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [2:0]       bit_reg, bit_next;
    logic [7:0]       byte_reg, byte_next;
    logic             eof_reg, eof_next;
    res_t             pend_reg;
    logic             pend_valid_reg;
    res_t             out_reg;
    logic             out_last_reg;
    logic             out_valid_reg;

    logic             emit_req;
    res_t             new_res;
    res_t             base;
    logic             stall;
    logic             out_busy;
    logic             push;
    logic             div_start;
    logic             div_done;
    logic [7:0]       div_quo;
    logic [NUM_W-1:0] div_num;
    logic [20:0]      acc_x10;
    logic [2*DIM_W-1:0] prod;
    logic [SL_W-1:0]  prod_w;
    logic [DIM_W:0]   col_inc;
    logic [31:0]      wid_ext;
    logic [31:0]      hgt_ext;
    logic             num_phase;
    logic             dim_bad;
    logic [SL_W-1:0]  left_dec;
    front_t           front;
    fin_t             fin;
    logic             rast_end;

    assign wid_ext   = 32'(wid_reg);
    assign hgt_ext   = 32'(hgt_reg);
    assign acc_x10   = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                       + {13'd0, byte_reg - CH_0};
    assign div_num   = {acc_reg, 8'd0} - {8'd0, acc_reg} + {10'd0, maxv_reg[15:1]};
    assign prod      = wid_reg * acc_reg[DIM_W-1:0];
    assign prod_w    = SL_W'(prod);
    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign num_phase = (ph_reg == PH_WIDTH) || (ph_reg == PH_HEIGHT)
                       || (ph_reg == PH_MAXVAL) || (ph_reg == PH_SAMPLES);
    assign dim_bad   = (acc_reg == '0) || ({15'd0, acc_reg} > 32'(MAX_DIM));
    assign left_dec  = (left_reg != '0) ? left_reg - 1'b1 : left_reg;

    always_comb
    begin
        base.sample = 8'd0;
        base.status = STS_SAMPLE;
        base.width  = wid_ext[12:0];
        base.height = hgt_ext[12:0];
        base.color  = (ph_reg != PH_MAGIC) && (ph_reg != PH_DIGIT) && (kind_reg == KIND_P3);
    end

    always_comb
    begin
        ph_next   = ph_reg;
        kind_next = kind_reg;
        acc_next  = acc_reg;
        seen_next = seen_reg;
        cmt_next  = cmt_reg;
        wid_next  = wid_reg;
        hgt_next  = hgt_reg;
        maxv_next = maxv_reg;
        left_next = left_reg;
        col_next  = col_reg;
        bit_next  = bit_reg;
        byte_next = byte_reg;
        eof_next  = eof_reg;
        emit_req  = 1'b0;
        new_res   = base;
        front     = FR_DONE;
        fin       = FIN_POST;
        rast_end  = 1'b0;
        div_start = 1'b0;

        case (cmd.op)
            OP_WAIT:
            begin
                if (cmd.load)
                begin
                    byte_next = data_in;
                    eof_next  = eof_in;
                end
            end
            OP_FRONT:
            begin
                if (eof_reg)
                begin
                    front = (num_phase && seen_reg) ? FR_FINISH : FR_EOF;
                end
                else if (ph_reg == PH_MAGIC)
                begin
                    if (byte_reg == CH_P)
                    begin
                        ph_next = PH_DIGIT;
                    end
                    else
                    begin
                        emit_req       = 1'b1;
                        new_res.status = STS_BAD_MAGIC;
                        ph_next        = PH_IDLE;
                    end
                end
                else if (ph_reg == PH_DIGIT)
                begin
                    if ((byte_reg >= CH_1) && (byte_reg <= CH_4))
                    begin
                        kind_next = 2'(byte_reg - CH_1);
                        ph_next   = PH_WIDTH;
                    end
                    else
                    begin
                        emit_req       = 1'b1;
                        new_res.status = STS_BAD_MAGIC;
                        ph_next        = PH_IDLE;
                    end
                end
                else if (ph_reg == PH_RASTER)
                begin
                    front    = FR_RASTER;
                    bit_next = 3'd7;
                end
                else if (num_phase)
                begin
                    if (cmt_reg)
                    begin
                        if (byte_reg == CH_LF)
                        begin
                            cmt_next = 1'b0;
                        end
                    end
                    else if (is_digit(byte_reg))
                    begin
                        acc_next  = (acc_x10 > {4'd0, ACC_MAX}) ? ACC_MAX : acc_x10[ACC_W-1:0];
                        seen_next = 1'b1;
                    end
                    else if (seen_reg)
                    begin
                        front = FR_FINISH;
                    end
                    else if (byte_reg == CH_HASH)
                    begin
                        cmt_next = 1'b1;
                    end
                    else if (!is_space(byte_reg))
                    begin
                        emit_req       = 1'b1;
                        new_res.status = STS_BAD_NUM;
                        ph_next        = PH_IDLE;
                    end
                end
            end
            OP_FINISH:
            begin
                acc_next  = '0;
                seen_next = 1'b0;
                case (ph_reg)
                    PH_WIDTH:
                    begin
                        if (dim_bad)
                        begin
                            emit_req       = 1'b1;
                            new_res.status = STS_BAD_DIM;
                            ph_next        = PH_IDLE;
                        end
                        else
                        begin
                            wid_next = acc_reg[DIM_W-1:0];
                            ph_next  = PH_HEIGHT;
                        end
                    end
                    PH_HEIGHT:
                    begin
                        if (dim_bad)
                        begin
                            emit_req       = 1'b1;
                            new_res.status = STS_BAD_DIM;
                            ph_next        = PH_IDLE;
                        end
                        else
                        begin
                            hgt_next  = acc_reg[DIM_W-1:0];
                            left_next = (kind_reg == KIND_P3) ? prod_w + (prod_w << 1) : prod_w;
                            col_next  = '0;
                            if (kind_reg == KIND_P4)
                            begin
                                ph_next = PH_RASTER;
                            end
                            else if (kind_reg == KIND_P1)
                            begin
                                ph_next = PH_SAMPLES;
                            end
                            else
                            begin
                                ph_next = PH_MAXVAL;
                            end
                        end
                    end
                    PH_MAXVAL:
                    begin
                        if ((acc_reg == '0) || (acc_reg[16]))
                        begin
                            emit_req       = 1'b1;
                            new_res.status = STS_BAD_MAXV;
                            ph_next        = PH_IDLE;
                        end
                        else
                        begin
                            maxv_next = acc_reg[15:0];
                            ph_next   = PH_SAMPLES;
                        end
                    end
                    PH_SAMPLES:
                    begin
                        if (kind_reg == KIND_P1)
                        begin
                            emit_req       = 1'b1;
                            new_res.sample = (acc_reg == '0) ? 8'd255 : 8'd0;
                            left_next      = left_dec;
                            fin            = FIN_SAMPLE;
                        end
                        else if ((maxv_reg == 16'd255) || (maxv_reg == 16'd0))
                        begin
                            emit_req       = 1'b1;
                            new_res.sample = (maxv_reg == 16'd0) ? 8'd0 : acc_reg[7:0];
                            left_next      = left_dec;
                            fin            = FIN_SAMPLE;
                        end
                        else
                        begin
                            div_start = 1'b1;
                            fin       = FIN_DIV;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_SDIV:
            begin
                emit_req       = 1'b1;
                new_res.sample = div_quo;
                left_next      = left_dec;
            end
            OP_CHK, OP_RDONE:
            begin
                if (left_reg == '0)
                begin
                    emit_req       = 1'b1;
                    new_res.status = STS_DONE;
                    ph_next        = PH_IDLE;
                end
            end
            OP_POST:
            begin
                if (eof_reg)
                begin
                    if (ph_reg != PH_IDLE)
                    begin
                        emit_req       = 1'b1;
                        new_res.status = STS_TRUNC;
                    end
                    ph_next   = PH_MAGIC;
                    kind_next = '0;
                    acc_next  = '0;
                    seen_next = 1'b0;
                    cmt_next  = 1'b0;
                    wid_next  = '0;
                    hgt_next  = '0;
                    maxv_next = '0;
                    left_next = '0;
                    col_next  = '0;
                end
                else if (ph_reg == PH_RASTER)
                begin
                    if (!is_space(byte_reg))
                    begin
                        emit_req       = 1'b1;
                        new_res.status = STS_BAD_NUM;
                        ph_next        = PH_IDLE;
                    end
                end
                else if (ph_reg != PH_IDLE)
                begin
                    if (byte_reg == CH_HASH)
                    begin
                        cmt_next = 1'b1;
                    end
                    else if (!is_space(byte_reg))
                    begin
                        emit_req       = 1'b1;
                        new_res.status = STS_BAD_NUM;
                        ph_next        = PH_IDLE;
                    end
                end
            end
            OP_RAST:
            begin
                if (left_reg == '0)
                begin
                    rast_end = 1'b1;
                end
                else
                begin
                    emit_req       = 1'b1;
                    new_res.sample = byte_reg[bit_reg] ? 8'd0 : 8'd255;
                    left_next      = left_reg - 1'b1;
                    bit_next       = bit_reg - 1'b1;
                    if (col_inc >= {1'b0, wid_reg})
                    begin
                        col_next = '0;
                        rast_end = 1'b1;
                    end
                    else
                    begin
                        col_next = col_inc[DIM_W-1:0];
                    end
                    if (bit_reg == 3'd0)
                    begin
                        rast_end = 1'b1;
                    end
                end
            end
            OP_FLUSH:
            begin
                emit_req = pend_valid_reg;
            end
            default:
            begin
            end
        endcase
    end

    // a new result first moves the staged one to the output register
    assign out_busy = out_valid_reg && !out_ready;
    assign stall    = emit_req && pend_valid_reg && out_busy;
    assign push     = emit_req && pend_valid_reg && !out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg         <= PH_MAGIC;
            kind_reg       <= '0;
            acc_reg        <= '0;
            seen_reg       <= 1'b0;
            cmt_reg        <= 1'b0;
            wid_reg        <= '0;
            hgt_reg        <= '0;
            maxv_reg       <= '0;
            left_reg       <= '0;
            col_reg        <= '0;
            bit_reg        <= '0;
            eof_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!stall)
            begin
                ph_reg   <= ph_next;
                kind_reg <= kind_next;
                acc_reg  <= acc_next;
                seen_reg <= seen_next;
                cmt_reg  <= cmt_next;
                wid_reg  <= wid_next;
                hgt_reg  <= hgt_next;
                maxv_reg <= maxv_next;
                left_reg <= left_next;
                col_reg  <= col_next;
                bit_reg  <= bit_next;
                eof_reg  <= eof_next;
                if (cmd.op == OP_FLUSH)
                begin
                    pend_valid_reg <= 1'b0;
                end
                else if (emit_req)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (!stall && emit_req && (cmd.op != OP_FLUSH))
        begin
            pend_reg <= new_res;
        end
        if (push)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= (cmd.op == OP_FLUSH);
        end
    end

    pabd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start && !stall),
        .num   (div_num),
        .den   (maxv_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        stat.stall    = stall;
        stat.front    = front;
        stat.fin      = fin;
        stat.div_done = div_done;
        stat.rast_end = rast_end;
    end

    assign out_res   = out_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: sv/pabd_ctrl.sv
// controller: sequences the work for one input beat
`default_nettype none

module pabd_ctrl
    import pabd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_WAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_WAIT;
        cmd.load   = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            CS_WAIT:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = CS_FRONT;
                end
            end
            CS_FRONT:
            begin
                cmd.op = OP_FRONT;
                if (!stat.stall)
                begin
                    case (stat.front)
                        FR_FINISH: state_next = CS_FINISH;
                        FR_EOF:    state_next = CS_POST;
                        FR_RASTER: state_next = CS_RAST;
                        default:   state_next = CS_FLUSH;
                    endcase
                end
            end
            CS_FINISH:
            begin
                cmd.op = OP_FINISH;
                if (!stat.stall)
                begin
                    case (stat.fin)
                        FIN_DIV:    state_next = CS_DIV;
                        FIN_SAMPLE: state_next = CS_CHK;
                        default:    state_next = CS_POST;
                    endcase
                end
            end
            CS_DIV:
            begin
                cmd.op = OP_WAITDIV;
                if (stat.div_done)
                begin
                    state_next = CS_SDIV;
                end
            end
            CS_SDIV:
            begin
                cmd.op = OP_SDIV;
                if (!stat.stall)
                begin
                    state_next = CS_CHK;
                end
            end
            CS_CHK:
            begin
                cmd.op = OP_CHK;
                if (!stat.stall)
                begin
                    state_next = CS_POST;
                end
            end
            CS_POST:
            begin
                cmd.op = OP_POST;
                if (!stat.stall)
                begin
                    state_next = CS_FLUSH;
                end
            end
            CS_RAST:
            begin
                cmd.op = OP_RAST;
                if (!stat.stall && stat.rast_end)
                begin
                    state_next = CS_RDONE;
                end
            end
            CS_RDONE:
            begin
                cmd.op = OP_RDONE;
                if (!stat.stall)
                begin
                    state_next = CS_FLUSH;
                end
            end
            CS_FLUSH:
            begin
                cmd.op = OP_FLUSH;
                if (!stat.stall)
                begin
                    state_next = CS_WAIT;
                end
            end
            default:
            begin
                state_next = CS_WAIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/pnm_ascii_bitmap_decoder_top.sv
// top level of the streaming pnm p1..p4 decoder
`default_nettype none

// Decodes a plain or bitmap PNM file (P1, P2, P3, P4) fed one byte per input
// beat and streams 8-bit samples in file order, then one "image done" beat;
// errors and truncation come out as status codes. The block works on one
// input byte at a time. A header or comment byte runs the front step; a byte
// that ends a number adds the finish and post steps; a P2/P3 sample whose
// maxval is not 255 also waits on the one-bit-per-cycle restoring divider;
// a P4 raster byte is unpacked into one sample per bit, up to 8. Every
// result is staged once so that tlast can mark the final result of its input
// byte, and the output register lets the next byte be taken while the last
// result still waits on m_axis_tready. Output stalls only hold the sequence.
module pnm_ascii_bitmap_decoder_top
    import pabd_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    input  wire logic               s_axis_tuser,   // end_of_file
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // [7:0] sample, [20:8] image_width,
                                                    // [33:21] image_height, rest zero
    output logic [TUSER_W-1:0]      m_axis_tuser,   // [2:0] status, [3] is_color
    output logic                    m_axis_tlast    // last_of_run
);

    cmd_t  cmd;
    stat_t stat;
    res_t  res;

    // sequencer for each accepted byte
    pabd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // parser state, scaling divider and result staging
    pabd_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .data_in   (s_axis_tdata),
        .eof_in    (s_axis_tuser),
        .out_ready (m_axis_tready),
        .out_res   (res),
        .out_last  (m_axis_tlast),
        .out_valid (m_axis_tvalid)
    );

    // pack the result beat
    assign m_axis_tdata = {6'd0, res.height, res.width, res.sample};
    assign m_axis_tuser = {res.color, res.status};

    // one byte at a time: a taken beat closes the input until its work is done
    a_one_byte : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while previous byte still in work");

    // only sample beats carry a nonzero sample
    a_sample_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] != STS_SAMPLE) |-> m_axis_tdata[7:0] == 8'd0)
        else $error("nonzero sample on a status beat");

    // the divider result is only awaited by the controller
    a_div_wait : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SDIV |-> stat.div_done)
        else $error("scaled sample taken before divider finished");

endmodule

`default_nettype wire
